// ===== rtl/core/pt64_pkg.sv =====
`default_nettype none
package pt64_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned BaseN  = 12;
  localparam int unsigned BaseIw = 4;
  localparam int unsigned BitIw  = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SPLIT,
    ST_BASE,
    ST_EXP_BIT,
    ST_EXP_MUL,
    ST_EXP_SQR,
    ST_CHECK,
    ST_SQR,
    ST_SQR_CHK,
    ST_DONE
  } pt64_state_t;

  // multiplier operand select
  typedef enum logic [1:0] {
    MUL_ACC_BASE,
    MUL_BASE_BASE,
    MUL_X_X
  } pt64_mul_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic          load;
    logic          split_step;
    logic          base_load;
    logic          mul_start;
    pt64_mul_sel_t mul_sel;
    logic          exp_shift;
    logic          sqr_count;
  } pt64_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic below_two;
    logic d_odd;
    logic n_is_base;
    logic exp_zero;
    logic exp_lsb;
    logic mul_done;
    logic x_is_one;
    logic x_is_nm1;
    logic sqr_left;
    logic base_last;
  } pt64_sts_t;

  function automatic logic [WordW-1:0] base_value(input logic [BaseIw-1:0] idx);
    logic [WordW-1:0] v;
    unique case (idx)
      4'd0:  v = 64'd2;
      4'd1:  v = 64'd3;
      4'd2:  v = 64'd5;
      4'd3:  v = 64'd7;
      4'd4:  v = 64'd11;
      4'd5:  v = 64'd13;
      4'd6:  v = 64'd17;
      4'd7:  v = 64'd19;
      4'd8:  v = 64'd23;
      4'd9:  v = 64'd29;
      4'd10: v = 64'd31;
      4'd11: v = 64'd37;
      default: v = 64'd2;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/prime_test_64bit_unit.sv =====
`default_nettype none
// channel | ports                          | width
// input   | in_valid in_ready in_candidate  | 64
// result  | out_valid out_ready out_prime_flag | 1
// one item at a time; each 64-bit mod-multiply runs on the shared
// bit-serial multiplier, about 128 of them per base over up to twelve bases
// reset is synchronous and clears the sequencer and the multiplier control flags only
// the result holds until out_ready; no new item is taken meanwhile
module prime_test_64bit_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_candidate,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_prime_flag
);

  pt64_pkg::pt64_cmd_t cmd;
  pt64_pkg::pt64_sts_t sts;

  pt64_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .prime_flag (out_prime_flag),
    .sts        (sts),
    .cmd        (cmd)
  );

  pt64_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .candidate (in_candidate),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

// ===== rtl/core/pt64_mulmod.sv =====
`default_nettype none
// shift-and-add modular multiplier, one bit of y per cycle
module pt64_mulmod (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [pt64_pkg::WordW-1:0]  x,
  input  wire logic [pt64_pkg::WordW-1:0]  y,
  input  wire logic [pt64_pkg::WordW-1:0]  m,
  output logic                             done,
  output logic [pt64_pkg::WordW-1:0]       prod
);

  logic                          busy_r, busy_nxt;
  logic [pt64_pkg::BitIw-1:0]    bit_r, bit_nxt;
  logic [pt64_pkg::WordW-1:0]    acc_r, acc_nxt;
  logic [pt64_pkg::WordW-1:0]    x_r, y_r;
  logic                          done_r, done_nxt;
  logic [pt64_pkg::WordW:0]      dbl, dbl_sub, sum, sum_sub;
  logic [pt64_pkg::WordW-1:0]    acc2;

  // double then conditionally add x, both mod m (operands already below m)
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_sub = dbl - {1'b0, m};
    acc2    = dbl_sub[pt64_pkg::WordW] ? dbl[pt64_pkg::WordW-1:0]
                                       : dbl_sub[pt64_pkg::WordW-1:0];
    sum     = {1'b0, acc2} + {1'b0, x_r};
    sum_sub = sum - {1'b0, m};
    acc_nxt = acc2;
    if (y_r[bit_r]) begin
      acc_nxt = sum_sub[pt64_pkg::WordW] ? sum[pt64_pkg::WordW-1:0]
                                         : sum_sub[pt64_pkg::WordW-1:0];
    end
    busy_nxt = busy_r;
    bit_nxt  = bit_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      bit_nxt  = '1;
      acc_nxt  = '0;
    end else if (busy_r) begin
      bit_nxt = bit_r - 1'b1;
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bit_r <= bit_nxt;
    acc_r <= acc_nxt;
    if (start) begin
      x_r <= x;
      y_r <= y;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

// ===== rtl/core/pt64_datapath.sv =====
`default_nettype none
// operand registers, exponent and squaring counters, compares
module pt64_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [pt64_pkg::WordW-1:0]  candidate,
  input  wire pt64_pkg::pt64_cmd_t         cmd,
  output pt64_pkg::pt64_sts_t              sts
);

  logic [pt64_pkg::WordW-1:0]  n_r, d_r, e_r, b_r, acc_r;
  logic [pt64_pkg::BitIw-1:0]  r_r, k_r;
  logic [pt64_pkg::BaseIw-1:0] bi_r;
  logic [pt64_pkg::WordW-1:0]  mx, my, prod, bval, nm1;
  logic                        mdone;

  assign bval = pt64_pkg::base_value(bi_r);
  assign nm1  = n_r - 64'd1;

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd.mul_sel)
      pt64_pkg::MUL_ACC_BASE:  begin mx = acc_r; my = b_r; end
      pt64_pkg::MUL_BASE_BASE: begin mx = b_r;   my = b_r; end
      default:                 begin mx = acc_r; my = acc_r; end
    endcase
  end

  pt64_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .x     (mx),
    .y     (my),
    .m     (n_r),
    .done  (mdone),
    .prod  (prod)
  );

  // register updates driven by controller commands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r  <= candidate;
      d_r  <= candidate - 64'd1;
      r_r  <= '0;
      bi_r <= '0;
    end
    if (cmd.split_step) begin
      d_r <= d_r >> 1;
      r_r <= r_r + 1'b1;
    end
    if (cmd.base_load) begin
      // bases are below any n reaching here except n equal to a base, which ST_BASE flags as prime
      b_r   <= (bval >= n_r) ? bval - n_r : bval;
      e_r   <= d_r;
      acc_r <= 64'd1;
      k_r   <= 6'd1;
    end
    if (mdone) begin
      unique case (cmd.mul_sel)
        pt64_pkg::MUL_BASE_BASE: b_r <= prod;
        default:                 acc_r <= prod;
      endcase
    end
    if (cmd.exp_shift) e_r <= e_r >> 1;
    if (cmd.sqr_count) k_r <= k_r + 1'b1;
    if (cmd.base_load && bi_r != pt64_pkg::BaseIw'(pt64_pkg::BaseN - 1)) begin
      bi_r <= bi_r + 1'b1;
    end
  end

  // status back to the controller
  always_comb begin
    sts.below_two = (candidate < 64'd2);
    sts.d_odd     = d_r[0];
    sts.n_is_base = (n_r == bval);
    sts.exp_zero  = (e_r == '0);
    sts.exp_lsb   = e_r[0];
    sts.mul_done  = mdone;
    sts.x_is_one  = (acc_r == 64'd1);
    sts.x_is_nm1  = (acc_r == nm1);
    sts.sqr_left  = (k_r < r_r);
    sts.base_last = (bi_r == pt64_pkg::BaseIw'(pt64_pkg::BaseN - 1));
  end

endmodule
`default_nettype wire

// ===== rtl/core/pt64_ctrl.sv =====
`default_nettype none
// sequencer for the witness loop over the bases, ending early on a witness or on n equal to a base
module pt64_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  prime_flag,
  input  wire pt64_pkg::pt64_sts_t sts,
  output pt64_pkg::pt64_cmd_t   cmd
);

  pt64_pkg::pt64_state_t state_r, state_nxt;
  logic                  flag_r, flag_nxt;
  logic                  busy_r, busy_nxt;
  logic                  last_r, last_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    flag_nxt  = flag_r;
    busy_nxt  = busy_r;
    last_nxt  = last_r;
    unique case (state_r)
      pt64_pkg::ST_IDLE: if (in_valid) begin
        if (sts.below_two) begin
          flag_nxt = 1'b0; state_nxt = pt64_pkg::ST_DONE;
        end else state_nxt = pt64_pkg::ST_SPLIT;
      end
      pt64_pkg::ST_SETUP: state_nxt = pt64_pkg::ST_BASE;
      pt64_pkg::ST_SPLIT: if (sts.d_odd) state_nxt = pt64_pkg::ST_BASE;
      pt64_pkg::ST_BASE: begin
        last_nxt = sts.base_last;
        if (sts.n_is_base) begin
          flag_nxt = 1'b1; state_nxt = pt64_pkg::ST_DONE;
        end else state_nxt = pt64_pkg::ST_EXP_BIT;
      end
      pt64_pkg::ST_EXP_BIT: begin
        if (sts.exp_zero) state_nxt = pt64_pkg::ST_CHECK;
        else if (sts.exp_lsb) state_nxt = pt64_pkg::ST_EXP_MUL;
        else state_nxt = pt64_pkg::ST_EXP_SQR;
        busy_nxt = 1'b0;
      end
      pt64_pkg::ST_EXP_MUL: begin
        busy_nxt = 1'b1;
        if (sts.mul_done) begin busy_nxt = 1'b0; state_nxt = pt64_pkg::ST_EXP_SQR; end
      end
      pt64_pkg::ST_EXP_SQR: begin
        busy_nxt = 1'b1;
        if (sts.mul_done) begin busy_nxt = 1'b0; state_nxt = pt64_pkg::ST_EXP_BIT; end
      end
      pt64_pkg::ST_CHECK: begin
        if (sts.x_is_one || sts.x_is_nm1) begin
          if (last_r) begin flag_nxt = 1'b1; state_nxt = pt64_pkg::ST_DONE; end
          else state_nxt = pt64_pkg::ST_BASE;
        end else if (sts.sqr_left) state_nxt = pt64_pkg::ST_SQR;
        else begin flag_nxt = 1'b0; state_nxt = pt64_pkg::ST_DONE; end
      end
      pt64_pkg::ST_SQR: begin
        busy_nxt = 1'b1;
        if (sts.mul_done) begin busy_nxt = 1'b0; state_nxt = pt64_pkg::ST_SQR_CHK; end
      end
      pt64_pkg::ST_SQR_CHK: begin
        if (sts.x_is_nm1) begin
          if (last_r) begin flag_nxt = 1'b1; state_nxt = pt64_pkg::ST_DONE; end
          else state_nxt = pt64_pkg::ST_BASE;
        end else if (sts.sqr_left) state_nxt = pt64_pkg::ST_SQR;
        else begin flag_nxt = 1'b0; state_nxt = pt64_pkg::ST_DONE; end
      end
      pt64_pkg::ST_DONE: if (out_ready) state_nxt = pt64_pkg::ST_IDLE;
      default: state_nxt = pt64_pkg::ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd            = '0;
    cmd.mul_sel    = pt64_pkg::MUL_X_X;
    in_ready       = (state_r == pt64_pkg::ST_IDLE);
    out_valid      = (state_r == pt64_pkg::ST_DONE);
    prime_flag     = flag_r;
    unique case (state_r)
      pt64_pkg::ST_IDLE:  cmd.load = in_valid;
      pt64_pkg::ST_SPLIT: cmd.split_step = !sts.d_odd;
      pt64_pkg::ST_BASE:  cmd.base_load = 1'b1;
      pt64_pkg::ST_EXP_MUL: begin
        cmd.mul_sel   = pt64_pkg::MUL_ACC_BASE;
        cmd.mul_start = !busy_r;
      end
      pt64_pkg::ST_EXP_SQR: begin
        cmd.mul_sel   = pt64_pkg::MUL_BASE_BASE;
        cmd.mul_start = !busy_r;
        cmd.exp_shift = sts.mul_done;
      end
      pt64_pkg::ST_SQR: begin
        cmd.mul_start = !busy_r;
        cmd.sqr_count = sts.mul_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pt64_pkg::ST_IDLE;
      busy_r  <= 1'b0;
      flag_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      flag_r  <= flag_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule
`default_nettype wire
